@@ rtl/vad_pkg.sv @@
// ----------------------------------------------------------------------------
// vad_pkg: shared constants for the vector angle datapath
// Fixed internal widths, CORDIC step count and the arctangent table in
// degrees scaled by 2^24.
// ----------------------------------------------------------------------------
package vad_pkg;

  localparam int unsigned NORM_BITS    = 15;  // magnitude width after scaling
  localparam int unsigned VEC_W        = NORM_BITS + 1;
  localparam int unsigned SQ_W         = 2 * VEC_W;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned PROD_W       = 2 * LEN_W;
  localparam int unsigned DEN_W        = PROD_W / 2;
  localparam int unsigned COS_BITS     = 30;
  localparam int unsigned QUO_W        = COS_BITS + 1;
  localparam int unsigned NUM_W        = 64;
  localparam int unsigned COS_W        = COS_BITS + 2;
  localparam int unsigned RAD_W        = 2 * COS_BITS + 1;
  localparam int unsigned SIN_W        = (RAD_W + 1) / 2;
  localparam int unsigned DEG_BITS     = 24;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned XY_W         = 34;
  localparam int unsigned Z_W          = 35;
  localparam int unsigned ANGLE_W      = 16;

  localparam logic [29:0] ATAN_DEG_TAB [CORDIC_STEPS] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
    30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
    30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
    30'd234684,    30'd117342,    30'd58671,     30'd29335,
    30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115
  };

endpackage

@@ rtl/vad_in_if.sv @@
// ----------------------------------------------------------------------------
// vad_in_if: request channel carrying two 3D vectors
// Valid/ready handshake with signed components.
// ----------------------------------------------------------------------------
interface vad_in_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] first_x;
  logic signed [W-1:0] first_y;
  logic signed [W-1:0] first_z;
  logic signed [W-1:0] second_x;
  logic signed [W-1:0] second_y;
  logic signed [W-1:0] second_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

@@ rtl/vad_out_if.sv @@
// ----------------------------------------------------------------------------
// vad_out_if: result channel carrying the angle and the degenerate flag
// Valid/ready handshake.
// ----------------------------------------------------------------------------
interface vad_out_if import vad_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_deg;
  logic               degenerate;

  modport source (output valid, angle_deg, degenerate, input ready);
  modport sink (input valid, angle_deg, degenerate, output ready);
endinterface

@@ rtl/vad_norm.sv @@
// ----------------------------------------------------------------------------
// vad_norm: vector scaling, squared lengths and dot product
// Five stages: magnitude and leading one, scaling, products, sums,
// product of the squared lengths.
// ----------------------------------------------------------------------------
module vad_norm import vad_pkg::*; #(
  parameter int unsigned COMPONENT_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [5:0][COMPONENT_WIDTH-1:0]     comp_i,
  output logic                                valid_o,
  output logic                                deg_o,
  output logic                                neg_o,
  output logic [DEN_W-1:0]                    dmag_o,
  output logic [PROD_W-1:0]                   lprod_o
);

  localparam int unsigned W  = COMPONENT_WIDTH;
  localparam int unsigned PW = $clog2(W);
  localparam int unsigned EW = W + NORM_BITS;

  logic [4:0] vld_q;

  // stage 1
  logic [W-1:0]  mag_d [6];
  logic [W-1:0]  mag_q [6];
  logic [5:0]    neg1_q;
  logic [PW-1:0] msb_d [2];
  logic [PW-1:0] msb_q [2];
  logic [1:0]    zero_d;
  logic [1:0]    zero_q;

  always_comb begin
    logic [W-1:0] cu;
    logic [W-1:0] orv;
    for (int j = 0; j < 6; j++) begin
      cu       = comp_i[j];
      mag_d[j] = cu[W-1] ? W'(~cu + 1'b1) : cu;
    end
    for (int v = 0; v < 2; v++) begin
      orv       = mag_d[3*v] | mag_d[3*v+1] | mag_d[3*v+2];
      zero_d[v] = (orv == '0);
      msb_d[v]  = '0;
      for (int b = 0; b < W; b++) begin
        if (orv[b]) msb_d[v] = PW'(b);
      end
    end
  end

  // stage 2: shift so the largest magnitude has its top bit at NORM_BITS-1
  logic [NORM_BITS-1:0]    scl [6];
  logic signed [VEC_W-1:0] vec_d [6];
  logic signed [VEC_W-1:0] vec_q [6];
  logic                    deg2_q;

  always_comb begin
    logic [EW-1:0]    ext;
    logic [VEC_W-1:0] sm;
    int               p;
    for (int j = 0; j < 6; j++) begin
      p   = int'(msb_q[j/3]);
      ext = EW'(mag_q[j]);
      if (p >= NORM_BITS - 1) begin
        scl[j] = NORM_BITS'(ext >> (p - (NORM_BITS - 1)));
      end else begin
        scl[j] = NORM_BITS'(ext << ((NORM_BITS - 1) - p));
      end
      sm       = {1'b0, scl[j]};
      vec_d[j] = neg1_q[j] ? $signed(~sm + 1'b1) : $signed(sm);
    end
  end

  // stage 3: squares and componentwise products for the dot product
  logic signed [SQ_W-1:0] sqa_q [3];
  logic signed [SQ_W-1:0] sqb_q [3];
  logic signed [SQ_W-1:0] xp_q  [3];
  logic                   deg3_q;

  // stage 4: sums
  logic [LEN_W-1:0]     la_d, lb_d, la_q, lb_q;
  logic signed [33:0]   dot;
  logic [DEN_W-1:0]     dmag_d, dmag4_q;
  logic                 neg4_q, deg4_q;

  always_comb begin
    la_d   = LEN_W'($unsigned(sqa_q[0])) + LEN_W'($unsigned(sqa_q[1]))
           + LEN_W'($unsigned(sqa_q[2]));
    lb_d   = LEN_W'($unsigned(sqb_q[0])) + LEN_W'($unsigned(sqb_q[1]))
           + LEN_W'($unsigned(sqb_q[2]));
    dot    = 34'(xp_q[0]) + 34'(xp_q[1]) + 34'(xp_q[2]);
    dmag_d = dot[33] ? DEN_W'(-dot) : DEN_W'(dot);
  end

  // stage 5
  logic [PROD_W-1:0] lprod_q;
  logic [DEN_W-1:0]  dmag5_q;
  logic              neg5_q, deg5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 6; j++) begin
        mag_q[j]  <= mag_d[j];
        neg1_q[j] <= comp_i[j][W-1];
        vec_q[j]  <= vec_d[j];
      end
      msb_q   <= msb_d;
      zero_q  <= zero_d;
      deg2_q  <= |zero_q;
      for (int j = 0; j < 3; j++) begin
        sqa_q[j] <= vec_q[j] * vec_q[j];
        sqb_q[j] <= vec_q[j+3] * vec_q[j+3];
        xp_q[j]  <= vec_q[j] * vec_q[j+3];
      end
      deg3_q  <= deg2_q;
      la_q    <= la_d;
      lb_q    <= lb_d;
      dmag4_q <= dmag_d;
      neg4_q  <= dot[33];
      deg4_q  <= deg3_q;
      lprod_q <= PROD_W'(la_q) * PROD_W'(lb_q);
      dmag5_q <= dmag4_q;
      neg5_q  <= neg4_q;
      deg5_q  <= deg4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign deg_o   = deg5_q;
  assign neg_o   = neg5_q;
  assign dmag_o  = dmag5_q;
  assign lprod_o = lprod_q;

  a_first_scaled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !zero_q[0] |-> (scl[0][NORM_BITS-1] || scl[1][NORM_BITS-1] ||
                                scl[2][NORM_BITS-1]))
    else $error("first vector not scaled to full range");

  a_second_scaled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !zero_q[1] |-> (scl[3][NORM_BITS-1] || scl[4][NORM_BITS-1] ||
                                scl[5][NORM_BITS-1]))
    else $error("second vector not scaled to full range");

endmodule

@@ rtl/vad_isqrt.sv @@
// ----------------------------------------------------------------------------
// vad_isqrt: pipelined integer square root
// One root bit per stage, floor result; a side word travels alongside.
// ----------------------------------------------------------------------------
module vad_isqrt #(
  parameter int unsigned IN_W   = 64,
  parameter int unsigned SIDE_W = 1,
  localparam int unsigned OUT_W = (IN_W + 1) / 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [OUT_W-1:0]  root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned TW = 2 * OUT_W + 1;

  logic [OUT_W-1:0]  vld_q;
  logic [TW-1:0]     rem_q  [OUT_W];
  logic [OUT_W-1:0]  root_q [OUT_W];
  logic [SIDE_W-1:0] side_q [OUT_W];

  for (genvar s = 0; s < OUT_W; s++) begin : g_stage
    localparam int unsigned K = OUT_W - 1 - s;
    logic [TW-1:0]     rem_in;
    logic [OUT_W-1:0]  root_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [TW-1:0]     term;
    logic              ge;

    if (s == 0) begin : g_head
      assign rem_in  = TW'(rad_i);
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_body
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k)
    assign term = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
    assign ge   = (rem_in >= term);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? rem_in - term : rem_in;
        root_q[s] <= root_in | (OUT_W'(ge) << K);
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[OUT_W-1];
  assign root_o  = root_q[OUT_W-1];
  assign side_o  = side_q[OUT_W-1];

endmodule

@@ rtl/vad_div.sv @@
// ----------------------------------------------------------------------------
// vad_div: cosine by restoring division, then the sine radicand
// Numerator stage, one quotient bit per stage, saturation, square and
// subtraction from one.
// ----------------------------------------------------------------------------
module vad_div import vad_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [DEN_W-1:0]        dmag_i,
  input  logic [DEN_W-1:0]        den_i,
  input  logic                    neg_i,
  input  logic                    deg_i,
  output logic                    valid_o,
  output logic [RAD_W-1:0]        rad_o,
  output logic signed [COS_W-1:0] cos_o,
  output logic                    deg_o
);

  localparam int unsigned NST = QUO_W + 4;

  logic [NST-1:0] vld_q;

  // numerator with the half divisor folded in for rounding
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den0_q;
  logic             neg0_q, deg0_q;

  logic [NUM_W-1:0] rem_q  [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];
  logic [DEN_W-1:0] den_q  [QUO_W];
  logic [QUO_W-1:0] negs_q;
  logic [QUO_W-1:0] degs_q;

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int unsigned K = QUO_W - 1 - s;
    logic [NUM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic             neg_in, deg_in;
    logic [NUM_W-1:0] dsh;
    logic             ge;

    if (s == 0) begin : g_head
      assign rem_in = num_q;
      assign quo_in = '0;
      assign den_in = den0_q;
      assign neg_in = neg0_q;
      assign deg_in = deg0_q;
    end else begin : g_body
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
      assign neg_in = negs_q[s-1];
      assign deg_in = degs_q[s-1];
    end

    assign dsh = NUM_W'(den_in) << K;
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? rem_in - dsh : rem_in;
        quo_q[s]  <= quo_in | (QUO_W'(ge) << K);
        den_q[s]  <= den_in;
        negs_q[s] <= neg_in;
        degs_q[s] <= deg_in;
      end
    end
  end

  // saturate to one, apply sign
  localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1) << COS_BITS;
  logic [QUO_W-1:0]        qsat_d, qsat_q;
  logic signed [COS_W-1:0] cos_d;
  logic signed [COS_W-1:0] cos1_q, cos2_q, cos3_q;
  logic                    deg1_q, deg2_q, deg3_q;
  logic [2*QUO_W-1:0]      sq_q;
  logic [RAD_W-1:0]        rad_q;

  always_comb begin
    qsat_d = (quo_q[QUO_W-1] > ONE_Q) ? ONE_Q : quo_q[QUO_W-1];
    cos_d  = negs_q[QUO_W-1] ? -$signed({1'b0, qsat_d}) : $signed({1'b0, qsat_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= (NUM_W'(dmag_i) << COS_BITS) + NUM_W'(den_i >> 1);
      den0_q <= den_i;
      neg0_q <= neg_i;
      deg0_q <= deg_i;
      qsat_q <= qsat_d;
      cos1_q <= cos_d;
      deg1_q <= degs_q[QUO_W-1];
      sq_q   <= qsat_q * qsat_q;
      cos2_q <= cos1_q;
      deg2_q <= deg1_q;
      rad_q  <= RAD_W'((2*QUO_W)'(1) << (2 * COS_BITS)) - RAD_W'(sq_q);
      cos3_q <= cos2_q;
      deg3_q <= deg2_q;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign rad_o   = rad_q;
  assign cos_o   = cos3_q;
  assign deg_o   = deg3_q;

endmodule

@@ rtl/vad_cordic.sv @@
// ----------------------------------------------------------------------------
// vad_cordic: arctangent of sine over cosine by CORDIC vectoring
// Quadrant fold, one rotation per stage, then clamp and round to degrees.
// ----------------------------------------------------------------------------
module vad_cordic import vad_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [COS_W-1:0] cos_i,
  input  logic [SIN_W-1:0]        sin_i,
  input  logic                    deg_i,
  output logic                    valid_o,
  output logic [ANGLE_W-1:0]      angle_o,
  output logic                    deg_o
);

  localparam int unsigned SH      = DEG_BITS - ANGLE_FRAC_BITS;
  localparam int unsigned NST     = CORDIC_STEPS + 2;
  localparam logic [32:0] Z_MAX   = 33'(180) << DEG_BITS;
  localparam logic [32:0] ANG_MAX = 33'(16'hFFFF);
  localparam logic [32:0] ANG_LIM = ((33'(180) << ANGLE_FRAC_BITS) > ANG_MAX) ?
                                    ANG_MAX : (33'(180) << ANGLE_FRAC_BITS);

  logic [NST-1:0] vld_q;

  logic signed [XY_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]  deg_q;

  // fold a negative cosine by a quarter turn
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cos_i[COS_W-1]) begin
        x_q[0] <= XY_W'($signed({1'b0, sin_i}));
        y_q[0] <= -XY_W'(cos_i);
        z_q[0] <= Z_W'(90) <<< DEG_BITS;
      end else begin
        x_q[0] <= XY_W'(cos_i);
        y_q[0] <= XY_W'($signed({1'b0, sin_i}));
        z_q[0] <= '0;
      end
      deg_q[0] <= deg_i;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  at;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = $signed(Z_W'(ATAN_DEG_TAB[i]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][XY_W-1]) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + at;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - at;
        end
        deg_q[i+1] <= deg_q[i];
      end
    end
  end

  // clamp to [0, 180], round half up, saturate; zero for a degenerate result
  logic [32:0]        zc, rnd;
  logic [ANGLE_W-1:0] ang_d, ang_q;
  logic               dego_q;

  always_comb begin
    priority if (z_q[CORDIC_STEPS][Z_W-1]) begin
      zc = '0;
    end else if (33'(z_q[CORDIC_STEPS]) > Z_MAX) begin
      zc = Z_MAX;
    end else begin
      zc = 33'(z_q[CORDIC_STEPS]);
    end
    rnd = (zc + (33'(1) << (SH - 1))) >> SH;
    if (deg_q[CORDIC_STEPS]) begin
      ang_d = '0;
    end else if (rnd > ANG_MAX) begin
      ang_d = '1;
    end else begin
      ang_d = ANGLE_W'(rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q  <= ang_d;
      dego_q <= deg_q[CORDIC_STEPS];
    end
  end

  assign valid_o = vld_q[NST-1];
  assign angle_o = ang_q;
  assign deg_o   = dego_q;

  a_x_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST-2] |-> !x_q[CORDIC_STEPS][XY_W-1])
    else $error("cordic x went negative");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST-1] && !dego_q |-> (33'(ang_q) <= ANG_LIM))
    else $error("angle beyond half turn");

endmodule

@@ rtl/vector_angle_degrees.sv @@
// Pipeline from request to result: scale/length, root of the length product,
//   division and sine radicand, sine root, CORDIC.
// Throughput: one request per cycle; the whole pipeline advances together
//   and holds in place while a finished result is not taken.
// Reset: valid bits of every stage clear; payload registers are not reset.
// ----------------------------------------------------------------------------
// vector_angle_degrees: angle between two 3D vectors in degrees
// Scales both vectors, forms the cosine by division, the sine by square
// root and the angle by CORDIC vectoring; unsigned fixed-point output.
// ----------------------------------------------------------------------------
module vector_angle_degrees import vad_pkg::*; #(
  parameter int unsigned COMPONENT_WIDTH = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vad_in_if.sink    req_i,
  vad_out_if.source rsp_o
);

  logic en;

  assign en        = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = en;

  logic [5:0][COMPONENT_WIDTH-1:0] comp;
  assign comp = {req_i.second_z, req_i.second_y, req_i.second_x,
                 req_i.first_z, req_i.first_y, req_i.first_x};

  logic              n_vld, n_deg, n_neg;
  logic [DEN_W-1:0]  n_dmag;
  logic [PROD_W-1:0] n_lprod;

  vad_norm #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .comp_i  (comp),
    .valid_o (n_vld),
    .deg_o   (n_deg),
    .neg_o   (n_neg),
    .dmag_o  (n_dmag),
    .lprod_o (n_lprod)
  );

  localparam int unsigned DSIDE_W = DEN_W + 2;
  logic               r_vld;
  logic [DEN_W-1:0]   r_den;
  logic [DSIDE_W-1:0] r_side;

  vad_isqrt #(.IN_W(PROD_W), .SIDE_W(DSIDE_W)) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n_vld),
    .rad_i   (n_lprod),
    .side_i  ({n_deg, n_neg, n_dmag}),
    .valid_o (r_vld),
    .root_o  (r_den),
    .side_o  (r_side)
  );

  logic                    d_vld, d_deg;
  logic [RAD_W-1:0]        d_rad;
  logic signed [COS_W-1:0] d_cos;

  vad_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_vld),
    .dmag_i  (r_side[DEN_W-1:0]),
    .den_i   (r_den),
    .neg_i   (r_side[DEN_W]),
    .deg_i   (r_side[DEN_W+1]),
    .valid_o (d_vld),
    .rad_o   (d_rad),
    .cos_o   (d_cos),
    .deg_o   (d_deg)
  );

  localparam int unsigned SSIDE_W = COS_W + 1;
  logic               s_vld;
  logic [SIN_W-1:0]   s_sin;
  logic [SSIDE_W-1:0] s_side;

  vad_isqrt #(.IN_W(RAD_W), .SIDE_W(SSIDE_W)) u_sin_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld),
    .rad_i   (d_rad),
    .side_i  ({d_deg, d_cos}),
    .valid_o (s_vld),
    .root_o  (s_sin),
    .side_o  (s_side)
  );

  vad_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_vld),
    .cos_i   ($signed(s_side[COS_W-1:0])),
    .sin_i   (s_sin),
    .deg_i   (s_side[COS_W]),
    .valid_o (rsp_o.valid),
    .angle_o (rsp_o.angle_deg),
    .deg_o   (rsp_o.degenerate)
  );

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.degenerate |-> (rsp_o.angle_deg == '0))
    else $error("degenerate result with nonzero angle");

endmodule

@@ tb/sv/vector_angle_degrees_tb.sv @@
// ----------------------------------------------------------------------------
// vector_angle_degrees_tb: self-checking bench for the vector angle block
// Drives vector pairs through the request channel in random bursts, stalls
// the result channel on its own pattern and compares every angle and
// degenerate flag against a bit-exact fixed-point angle predictor.
// ----------------------------------------------------------------------------
module vector_angle_degrees_tb;
  import vad_pkg::*;

  localparam int unsigned CW        = 16;
  localparam int unsigned FRAC      = 8;
  localparam int unsigned DRAIN_CYC = 200;
  localparam int unsigned N_RANDOM  = 1030;

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
  } vec_pair_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               degen;
  } angle_res_t;

  // --------------------------------------------------------------------------
  class angle_scoreboard;
    angle_res_t pending_q[$];
    int unsigned mismatches;

    static function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Scale so the largest magnitude lands in [2^14, 2^15); zero vector -> 0.
    static function automatic bit scale_vec(input logic signed [CW-1:0] cx, cy, cz,
                                            output longint v[3]);
      longint mag[3];
      bit neg[3];
      longint m;
      int rs, ls;
      logic signed [CW-1:0] c[3];
      c = '{cx, cy, cz};
      m = 0;
      rs = 0;
      ls = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = c[i] < 0;
        mag[i] = neg[i] ? -longint'(c[i]) : longint'(c[i]);
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) return 0;
      while (m >= (64'd1 << 15)) begin
        m >>= 1;
        rs++;
      end
      while (m < (64'd1 << 14)) begin
        m <<= 1;
        ls++;
      end
      for (int i = 0; i < 3; i++) begin
        v[i] = (mag[i] >> rs) << ls;
        if (neg[i]) v[i] = -v[i];
      end
      return 1;
    endfunction

    static function automatic angle_res_t predict_angle(vec_pair_t p);
      longint atan_deg[24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115};
      longint a[3], b[3];
      longint unsigned la, lb, den, dmag, q, s, ang;
      longint dot, c, x, y, z, xs, ys;
      angle_res_t r;
      bit oka, okb;
      oka = scale_vec(p.ax, p.ay, p.az, a);
      okb = scale_vec(p.bx, p.by, p.bz, b);
      if (!oka || !okb) begin
        r.angle = '0;
        r.degen = 1'b1;
        return r;
      end
      la = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
      lb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
      dot = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
      den = isqrt(la * lb);
      dmag = dot < 0 ? longint'(-dot) : longint'(dot);
      q = ((dmag << 30) + den / 2) / den;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      c = dot < 0 ? -longint'(q) : longint'(q);
      s = isqrt((64'd1 << 60) - q * q);
      x = c;
      y = longint'(s);
      z = 0;
      if (x < 0) begin
        x = longint'(s);
        y = -c;
        z = longint'(90) << 24;
      end
      for (int i = 0; i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += atan_deg[i];
        end else begin
          x -= ys;
          y += xs;
          z -= atan_deg[i];
        end
      end
      if (z < 0) z = 0;
      if (z > (longint'(180) << 24)) z = longint'(180) << 24;
      ang = (longint'(z) + (64'd1 << (24 - FRAC - 1))) >> (24 - FRAC);
      if (ang > 65535) ang = 65535;
      r.angle = ang[ANGLE_W-1:0];
      r.degen = 1'b0;
      return r;
    endfunction

    function void note_request(vec_pair_t p);
      pending_q.push_back(predict_angle(p));
    endfunction

    function void check_result(logic [ANGLE_W-1:0] angle, logic degen);
      angle_res_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result angle=%0d degenerate=%0b", angle, degen);
        return;
      end
      exp_r = pending_q.pop_front();
      if (angle !== exp_r.angle || degen !== exp_r.degen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: angle exp %0d got %0d, degenerate exp %0b got %0b",
                   exp_r.angle, angle, exp_r.degen, degen);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  vad_in_if #(.W(CW)) req_if();
  vad_out_if          rsp_if();

  vector_angle_degrees #(
    .COMPONENT_WIDTH(CW),
    .ANGLE_FRAC_BITS(FRAC)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  angle_scoreboard sb = new();
  int unsigned     cyc;
  int unsigned     burst_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: check accepted results, then pick next ready from a pattern.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_result(rsp_if.angle_deg, rsp_if.degenerate);
    case ((cyc / 317) % 4)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
      2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_if.ready <= ((cyc % 7) < 3);
    endcase
  end

  // Hold the request until accepted; keep valid high inside a burst.
  task automatic send_pair(vec_pair_t p);
    int unsigned gap;
    req_if.valid    <= 1'b1;
    req_if.first_x  <= p.ax;
    req_if.first_y  <= p.ay;
    req_if.first_z  <= p.az;
    req_if.second_x <= p.bx;
    req_if.second_y <= p.by;
    req_if.second_z <= p.bz;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0:       return CW'($urandom_range(0, 15) - 8);
      1:       return CW'($urandom_range(0, 511) - 256);
      2:       return ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send_comps(int ax, ay, az, bx, by, bz);
    vec_pair_t p;
    p.ax = CW'(ax); p.ay = CW'(ay); p.az = CW'(az);
    p.bx = CW'(bx); p.by = CW'(by); p.bz = CW'(bz);
    send_pair(p);
  endtask

  initial begin
    vec_pair_t p;
    int unsigned k;
    cyc = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.first_x = '0;
    req_if.first_y = '0;
    req_if.first_z = '0;
    req_if.second_x = '0;
    req_if.second_y = '0;
    req_if.second_z = '0;
    rsp_if.ready = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero vectors on either side and both
    send_comps(0, 0, 0, 16384, 0, 0);
    send_comps(100, -5, 3, 0, 0, 0);
    send_comps(0, 0, 0, 0, 0, 0);
    // parallel, antiparallel, orthogonal
    send_comps(16384, 0, 0, 16384, 0, 0);
    send_comps(16384, 0, 0, -16384, 0, 0);
    send_comps(0, 16384, 0, 0, 0, 16384);
    send_comps(1, 1, 1, 32767, 32767, 32767);
    send_comps(1, 1, 1, -32768, -32768, -32768);
    // most negative component
    send_comps(-32768, 0, 0, 32767, 0, 0);
    send_comps(-32768, -32768, -32768, -32768, 32767, 0);
    send_comps(32767, 32767, 32767, -32768, -32768, -32768);
    send_comps(-1, 0, 0, 0, -1, 0);
    send_comps(1, 0, 0, 1, 1, 0);
    send_comps(3, -7, 2, -1, 5, 9);
    send_comps(16384, 16383, 0, 16384, 16384, 1);
    send_comps(-2, -3, 5, 2, 3, -5);
    send_comps(12345, -23456, 31000, 12345, -23456, 31001);
    send_comps(32767, 0, 0, 32767, 1, 0);

    for (k = 0; k < N_RANDOM; k++) begin
      p.ax = rand_comp(); p.ay = rand_comp(); p.az = rand_comp();
      case ($urandom_range(0, 9))
        0: begin  // near parallel or antiparallel
          p.bx = CW'(p.ax + $urandom_range(0, 6) - 3);
          p.by = CW'(p.ay + $urandom_range(0, 6) - 3);
          p.bz = CW'(p.az + $urandom_range(0, 6) - 3);
          if ($urandom_range(0, 1) != 0) begin
            p.bx = -p.bx; p.by = -p.by; p.bz = -p.bz;
          end
        end
        1: begin  // zero vector on one side
          p.bx = 0; p.by = 0; p.bz = 0;
          if ($urandom_range(0, 1) != 0) begin
            p.bx = p.ax; p.by = p.ay; p.bz = p.az;
            p.ax = 0; p.ay = 0; p.az = 0;
          end
        end
        2: begin  // first vector shifted right by a power of two
          p.bx = p.ax >>> 3; p.by = p.ay >>> 3; p.bz = p.az >>> 3;
        end
        default: begin
          p.bx = rand_comp(); p.by = rand_comp(); p.bz = rand_comp();
        end
      endcase
      send_pair(p);
    end
    req_if.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
